>>> sv/mqf_pkg.sv
// Shared types and constants for the multi-queue block with urgent front insertion.
`timescale 1ns / 1ps
package mqf_pkg;

    // Default sizes of the bank
    localparam int NUM_QUEUES_DEF = 32;
    localparam int DEPTH_DEF      = 8;
    localparam int ID_WIDTH_DEF   = 16;

    // Fixed field widths
    localparam int QIDX_W   = 5;
    localparam int ITEM_W   = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;
    localparam int LIMIT_W  = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

    // Command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED  = 3'd0,
        ST_FULL   = 3'd1,
        ST_TAKEN  = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BADIDX = 3'd4
    } t_status;

    // Where a slot cell takes its new value from
    typedef enum logic [1:0] {
        SRC_ID,
        SRC_LEFT,
        SRC_RIGHT
    } t_src;

    // Per-cell write control
    typedef struct packed {
        logic wr;
        t_src src;
    } t_cell_ctrl;

endpackage

>>> sv/mqf_in_if.sv
// Command channel: valid/ready handshake with one queue command as payload.
`timescale 1ns / 1ps
interface mqf_in_if import mqf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [QIDX_W-1:0] queue_index;
    logic [ITEM_W-1:0] item_id;
    logic              urgent;

    modport source (output valid, cmd, queue_index, item_id, urgent, input ready);
    modport sink   (input valid, cmd, queue_index, item_id, urgent, output ready);
endinterface

>>> sv/mqf_out_if.sv
// Result channel: valid/ready handshake with one command result as payload.
`timescale 1ns / 1ps
interface mqf_out_if import mqf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] result_status;
    logic [ITEM_W-1:0]   taken_id;
    logic [COUNT_W-1:0]  queue_count;

    modport source (output valid, result_status, taken_id, queue_count, input ready);
    modport sink   (input valid, result_status, taken_id, queue_count, output ready);
endinterface

>>> sv/mqf_cell.sv
// Slot cell: holds one slot position of every queue and shifts with its neighbors.
`timescale 1ns / 1ps
module mqf_cell import mqf_pkg::*; #(
    parameter int NUM_QUEUES = NUM_QUEUES_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF,
    parameter int AW         = 5
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic [AW-1:0]       i_wr_addr,
    input  t_cell_ctrl          i_ctrl,
    input  logic [ID_WIDTH-1:0] i_id,
    input  logic [ID_WIDTH-1:0] i_left,
    input  logic [ID_WIDTH-1:0] i_right,
    output logic [ID_WIDTH-1:0] o_data
);

    logic [ID_WIDTH-1:0] r_mem [NUM_QUEUES];
    logic [ID_WIDTH-1:0] r_data;
    logic [ID_WIDTH-1:0] n_data;

    // Pick the new slot value: fresh id, shift toward tail, or shift toward head
    always_comb begin
        case (i_ctrl.src)
            SRC_ID:    n_data = i_id;
            SRC_LEFT:  n_data = i_left;
            SRC_RIGHT: n_data = i_right;
            default:   n_data = r_data;
        endcase
    end

    // Write back on commit, read the addressed queue's slot on transfer
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_mem[i_wr_addr] <= n_data;
        end
        if (i_rd_en) begin
            r_data <= r_mem[i_rd_addr];
        end
    end

    assign o_data = r_data;

endmodule

>>> sv/multi_queue_urgent_front_insert_top.sv
// After a command transfer the command is held in the busy state; its result is then
// written to the output register, later while a stalled result still holds it.
// A new command is taken only after the held one commits, set by the read-then-write
// of the slot cell memories (read at transfer, shift and write back at commit).
// A stalled result waits in the output register while the next command is taken.
// Reset (synchronous, active low) clears all queue counts, sets the limit to 5.
`timescale 1ns / 1ps
module multi_queue_urgent_front_insert_top import mqf_pkg::*; #(
    parameter int NUM_QUEUES = NUM_QUEUES_DEF,
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mqf_in_if.sink             i_in,
    mqf_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    localparam int AW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_state;

    t_state r_state;

    // Command held during the busy state
    logic                r_cmd;
    logic [AW-1:0]       r_addr;
    logic                r_bad;
    logic [ID_WIDTH-1:0] r_id;
    logic                r_urgent;
    logic [CW-1:0]       r_n;
    logic [LIMIT_W-1:0]  r_limit;
    logic [CW-1:0]       r_counts [NUM_QUEUES];

    // Output register
    logic                r_out_valid;
    t_status             r_status;
    logic [ITEM_W-1:0]   r_taken;
    logic [COUNT_W-1:0]  r_count;

    logic                w_accept;
    logic [AW-1:0]       w_in_addr;
    logic                w_in_bad;
    logic                w_commit;
    logic                w_full;
    logic                w_empty;
    logic                w_add_ok;
    logic                w_take_ok;
    t_status             n_status;
    logic [ITEM_W-1:0]   n_taken;
    logic [CW-1:0]       n_n;
    logic [ID_WIDTH-1:0] w_data [DEPTH];
    t_cell_ctrl          w_ctrl [DEPTH];

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_addr  = AW'(i_in.queue_index);
    assign w_in_bad   = (32'(i_in.queue_index) >= 32'(NUM_QUEUES));
    assign w_commit   = (r_state == S_BUSY) && (!r_out_valid || o_out.ready);

    // Add is refused once the count reaches the limit, capped at the depth
    assign w_full    = (32'(r_n) >= ((32'(r_limit) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(r_limit)));
    assign w_empty   = (r_n == '0);
    assign w_add_ok  = !r_bad && (r_cmd == CMD_ADD) && !w_full;
    assign w_take_ok = !r_bad && (r_cmd == CMD_TAKE) && !w_empty;

    // Result of the held command
    always_comb begin
        n_taken = '0;
        n_n     = r_n;
        if (r_bad) begin
            n_status = ST_BADIDX;
            n_n      = '0;
        end else if (r_cmd == CMD_ADD) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_ADDED;
                n_n      = r_n + 1'b1;
            end
        end else if (w_empty) begin
            n_status = ST_EMPTY;
        end else begin
            n_status = ST_TAKEN;
            n_taken  = ITEM_W'(w_data[0]);
            n_n      = r_n - 1'b1;
        end
    end

    // Chain of slot cells, head at position zero
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [ID_WIDTH-1:0] w_left;
        logic [ID_WIDTH-1:0] w_right;

        if (k == 0) begin : g_head
            assign w_left = r_id;
        end else begin : g_mid_l
            assign w_left = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_tail
            assign w_right = w_data[k];
        end else begin : g_mid_r
            assign w_right = w_data[k+1];
        end

        // Urgent add shifts the row toward the tail, take shifts toward the head
        always_comb begin
            w_ctrl[k].wr  = 1'b0;
            w_ctrl[k].src = SRC_ID;
            if (w_commit && w_add_ok && r_urgent) begin
                w_ctrl[k].wr  = 1'b1;
                w_ctrl[k].src = SRC_LEFT;
            end else if (w_commit && w_add_ok) begin
                w_ctrl[k].wr  = (32'(r_n) == k);
                w_ctrl[k].src = SRC_ID;
            end else if (w_commit && w_take_ok) begin
                w_ctrl[k].wr  = 1'b1;
                w_ctrl[k].src = SRC_RIGHT;
            end
        end

        mqf_cell #(
            .NUM_QUEUES (NUM_QUEUES),
            .ID_WIDTH   (ID_WIDTH),
            .AW         (AW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rd_en   (w_accept),
            .i_rd_addr (w_in_addr),
            .i_wr_addr (r_addr),
            .i_ctrl    (w_ctrl[k]),
            .i_id      (r_id),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_data    (w_data[k])
        );
    end

    // Hold the command and the addressed count on transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_in.cmd;
            r_addr   <= w_in_addr;
            r_bad    <= w_in_bad;
            r_id     <= ID_WIDTH'(i_in.item_id);
            r_urgent <= i_in.urgent;
            r_n      <= w_in_bad ? '0 : r_counts[w_in_addr];
        end
    end

    // Queue counts and the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_counts[q] <= '0;
            end
            r_limit <= LIMIT_RESET;
        end else begin
            if (w_commit && (w_add_ok || w_take_ok)) begin
                r_counts[r_addr] <= n_n;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_commit) begin
            r_status <= n_status;
            r_taken  <= n_taken;
            r_count  <= COUNT_W'(n_n);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_status = r_status;
    assign o_out.taken_id      = r_taken;
    assign o_out.queue_count   = r_count;

endmodule

>>> sv/mqf_check.sv
// Port-level checker for the multi-queue block, bound to the top level.
`timescale 1ns / 1ps
module mqf_check import mqf_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [ITEM_W-1:0]   i_taken,
    input logic [COUNT_W-1:0]  i_count
);

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_taken) && $stable(i_count))
        else $error("result changed while stalled");

    // A command transfer is never followed by another in the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken while previous one in progress");

    // Only a take returns an identifier
    a_taken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_TAKEN) |-> (i_taken == '0))
        else $error("nonzero identifier on a result that is not a take");

    // Successful add leaves a nonempty queue, empty or bad index reports zero
    a_count_sense: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_EMPTY || i_status == ST_BADIDX) |-> (i_count == '0))
        else $error("nonzero count on empty take or bad index");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_ADDED) |-> (i_count != '0))
        else $error("zero count after an add");

endmodule

bind multi_queue_urgent_front_insert_top mqf_check u_mqf_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.result_status),
    .i_taken     (o_out.taken_id),
    .i_count     (o_out.queue_count)
);
